>>> sv/tree_ancestor_query_assert.svh
// Assertion macros shared by the checker of the ancestor query block.
`ifndef TREE_ANCESTOR_QUERY_ASSERT_SVH
`define TREE_ANCESTOR_QUERY_ASSERT_SVH

// The condition must hold in the cycle after the trigger is seen.
`define TAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The condition must hold in the same cycle as the trigger.
`define TAQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/taq_pkg.sv
// Shared types, field widths, command codes and sequencer states of the ancestor query block.
package taq_pkg;

  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  localparam int CMD_W   = 2;
  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int LVL_W   = 4;
  localparam int STEP_W  = 10;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_field_t;
  typedef logic [STEP_W-1:0]  steps_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_JUMP  = 2'd0,
    CMD_WR_DEPTH = 2'd1,
    CMD_LCA      = 2'd2,
    CMD_LA       = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEP_B,
    ST_ORDER,
    ST_LIFT_J,
    ST_LIFT_D,
    ST_LIFT_END,
    ST_PAIR,
    ST_PAIR_END,
    ST_PARENT,
    ST_CLIMB,
    ST_CLIMB_END,
    ST_DONE
  } state_t;

endpackage

>>> sv/taq_if.sv
// Request and response channel interfaces of the ancestor query block.
interface taq_req_if;
  import taq_pkg::*;

  logic       valid;
  logic       ready;
  cmd_t       cmd;
  node_t      node_a;
  node_t      node_b;
  lvl_field_t jump_level;
  node_t      entry_value;
  steps_t     steps;

  modport source (output valid, cmd, node_a, node_b, jump_level, entry_value, steps,
                  input ready);
  modport sink (input valid, cmd, node_a, node_b, jump_level, entry_value, steps,
                output ready);
endinterface

interface taq_rsp_if;
  import taq_pkg::*;

  logic  valid;
  logic  ready;
  node_t answer_node;

  modport source (output valid, answer_node, input ready);
  modport sink (input valid, answer_node, output ready);
endinterface

>>> sv/taq_jump_ram.sv
// Jump table memory: one write port and two registered read ports.
module taq_jump_ram #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> sv/taq_depth_ram.sv
// Depth table memory: one write port and one registered read port.
module taq_depth_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tree_ancestor_query.sv
// Top level of the ancestor query block: sequencer, output register and the two table memories.
//
// This block answers lowest common ancestor and level ancestor queries over a
// binary-lifting jump table and a per-node depth table, both held in on-chip
// synchronous memories and loaded by write transfers on the request channel.
// A write transfer is absorbed in the cycle it is accepted and produces no
// response. A query occupies the block until its answer is placed in the
// response register; the next request is taken as soon as the sequencer is
// back in its idle state, even while that answer still waits on the response
// channel. A level ancestor query reads the jump table once per level. A
// common ancestor query first lifts the deeper node, which needs a jump table
// read followed by a depth table read at every level; the joint lift then
// reads both nodes' jump entries together through the two read ports of the
// jump memory. A query of a node with itself goes straight from the idle
// state to the done state. A query that names a node at or above NODES is
// accepted and dropped without a response; write transfers out of range are
// ignored. Neither memory is cleared: a query that touches an entry never
// written returns an unspecified node.
module tree_ancestor_query #(
  parameter int NODES  = taq_pkg::NODES_DEF,
  parameter int LEVELS = taq_pkg::LEVELS_DEF
) (
  input logic       clk,
  input logic       rst,
  taq_req_if.sink   req,
  taq_rsp_if.source rsp
);
  import taq_pkg::*;

  localparam int AW  = $clog2(NODES);
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JAW = AW + LW;
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  state_t state, state_next;

  // Working registers of the query in flight.
  node_t          v;
  node_t          u;
  node_t          up;
  depth_t         dv;
  steps_t         k;
  logic [LW-1:0]  lvl;
  logic           pend;
  logic           keep;
  node_t          ans;

  // Response register.
  logic  out_valid;
  node_t out_node;

  // Memory ports.
  logic           j_we;
  logic [JAW-1:0] j_waddr;
  logic [JAW-1:0] j_ra0;
  logic [JAW-1:0] j_ra1;
  node_t          j_rd0;
  node_t          j_rd1;
  logic           d_we;
  logic [AW-1:0]  d_ra;
  depth_t         d_rd;

  logic   accept;
  logic   a_ok;
  logic   b_ok;
  logic   lvl_ok;
  logic   val_ok;
  logic   slot_free;

  // Values after folding in the read that returned this cycle.
  node_t  lift_u;
  logic   pair_diff;
  node_t  pair_v;
  node_t  pair_u;
  node_t  climb_v;
  logic   take;
  steps_t span;

  assign accept    = req.valid && req.ready;
  assign a_ok      = 32'(req.node_a) < 32'(NODES);
  assign b_ok      = 32'(req.node_b) < 32'(NODES);
  assign lvl_ok    = 32'(req.jump_level) < 32'(LEVELS);
  assign val_ok    = 32'(req.entry_value) < 32'(NODES);
  assign slot_free = !out_valid || rsp.ready;

  // Table loads go straight to the memories in the cycle of the transfer.
  assign j_we    = accept && (req.cmd == CMD_WR_JUMP) && a_ok && lvl_ok && val_ok;
  assign j_waddr = {AW'(req.node_a), LW'(req.jump_level)};
  assign d_we    = accept && (req.cmd == CMD_WR_DEPTH) && a_ok;

  // A pending lift step is taken when the ancestor is not above the shallower node.
  assign lift_u    = (pend && (d_rd >= dv)) ? up : u;
  // A pending joint step is taken while the two ancestors still differ.
  assign pair_diff = pend && (j_rd0 != j_rd1);
  assign pair_v    = pair_diff ? j_rd0 : v;
  assign pair_u    = pair_diff ? j_rd1 : u;
  // A pending climb step always lands on the ancestor that was read.
  assign climb_v   = pend ? j_rd0 : v;
  // The jump of 2^lvl fits while the remaining count has a bit at or above lvl.
  assign take      = (k >> lvl) != '0;
  assign span      = steps_t'(1) << lvl;

  taq_jump_ram #(
    .ADDR_W (JAW),
    .DATA_W (NODE_W)
  ) u_jump_ram (
    .clk    (clk),
    .we     (j_we),
    .waddr  (j_waddr),
    .wdata  (req.entry_value),
    .raddr0 (j_ra0),
    .raddr1 (j_ra1),
    .rdata0 (j_rd0),
    .rdata1 (j_rd1)
  );

  taq_depth_ram #(
    .ADDR_W (AW),
    .DATA_W (DEPTH_W)
  ) u_depth_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (AW'(req.node_a)),
    .wdata (req.entry_value),
    .raddr (d_ra),
    .rdata (d_rd)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_LCA: begin
              if (!(a_ok && b_ok) || (req.node_a == req.node_b)) begin
                state_next = ST_DONE;
              end else begin
                state_next = ST_DEP_B;
              end
            end
            CMD_LA:  state_next = a_ok ? ST_CLIMB : ST_DONE;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DEP_B:     state_next = ST_ORDER;
      ST_ORDER:     state_next = ST_LIFT_J;
      ST_LIFT_J:    state_next = ST_LIFT_D;
      ST_LIFT_D:    state_next = (lvl == '0) ? ST_LIFT_END : ST_LIFT_J;
      ST_LIFT_END:  state_next = (v == lift_u) ? ST_DONE : ST_PAIR;
      ST_PAIR:      state_next = (lvl == '0) ? ST_PAIR_END : ST_PAIR;
      ST_PAIR_END:  state_next = ST_PARENT;
      ST_PARENT:    state_next = ST_DONE;
      ST_CLIMB:     state_next = (lvl == '0) ? ST_CLIMB_END : ST_CLIMB;
      ST_CLIMB_END: state_next = ST_DONE;
      ST_DONE:      state_next = (!keep || slot_free) ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Request ready and memory read addresses.
  assign req.ready = (state == ST_IDLE);

  always_comb begin
    j_ra0 = {AW'(u), lvl};
    j_ra1 = {AW'(u), lvl};
    d_ra  = AW'(u);
    case (state)
      ST_IDLE:     d_ra = AW'(req.node_a);
      ST_LIFT_J:   j_ra0 = {AW'(lift_u), lvl};
      ST_LIFT_D:   d_ra = AW'(j_rd0);
      ST_PAIR: begin
        j_ra0 = {AW'(pair_v), lvl};
        j_ra1 = {AW'(pair_u), lvl};
      end
      ST_PAIR_END: j_ra0 = {AW'(pair_u), {LW{1'b0}}};
      ST_CLIMB:    j_ra0 = {AW'(climb_v), lvl};
      default:     d_ra = AW'(u);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath of the query in flight.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          v    <= req.node_a;
          u    <= req.node_b;
          k    <= req.steps;
          ans  <= req.node_a;
          lvl  <= LVL_TOP;
          pend <= 1'b0;
          keep <= (req.cmd == CMD_LCA) ? (a_ok && b_ok) : a_ok;
        end
      end
      ST_DEP_B: dv <= d_rd;
      ST_ORDER: begin
        // Keep the deeper node in u and the shallower node's depth in dv.
        if (dv > d_rd) begin
          v  <= u;
          u  <= v;
          dv <= d_rd;
        end
      end
      ST_LIFT_J: u <= lift_u;
      ST_LIFT_D: begin
        up   <= j_rd0;
        pend <= 1'b1;
        if (lvl != '0) begin
          lvl <= lvl - 1'b1;
        end
      end
      ST_LIFT_END: begin
        u    <= lift_u;
        ans  <= v;
        pend <= 1'b0;
        lvl  <= LVL_TOP;
      end
      ST_PAIR: begin
        v    <= pair_v;
        u    <= pair_u;
        pend <= 1'b1;
        if (lvl != '0) begin
          lvl <= lvl - 1'b1;
        end
      end
      ST_PARENT: ans <= j_rd0;
      ST_CLIMB: begin
        v    <= climb_v;
        pend <= take;
        if (take) begin
          k <= k - span;
        end
        if (lvl != '0) begin
          lvl <= lvl - 1'b1;
        end
      end
      ST_CLIMB_END: ans <= climb_v;
      default: ;
    endcase
  end

  // Response register: loaded from the finished query once the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && keep && slot_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && keep && slot_free) begin
      out_node <= ans;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.answer_node = out_node;

endmodule

>>> sv/taq_checker.sv
// Port-level checker of the ancestor query block and its bind to the top level.
`include "tree_ancestor_query_assert.svh"

module taq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input taq_pkg::cmd_t  req_cmd,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input taq_pkg::node_t rsp_answer_node
);
  import taq_pkg::*;

  // Table loads finish in their own cycle, so the block stays open for the next transfer.
  `TAQ_ASSERT_NEXT(a_write_keeps_ready, req_valid && req_ready && (req_cmd == CMD_WR_JUMP || req_cmd == CMD_WR_DEPTH), req_ready, "write transfer closed the request channel")

  // A query owns the sequencer, so the request channel must close right after it.
  `TAQ_ASSERT_NEXT(a_query_blocks, req_valid && req_ready && (req_cmd == CMD_LCA || req_cmd == CMD_LA), !req_ready, "request taken while a query was in flight")

  // No answer can be produced in the cycle right after a request transfer.
  `TAQ_ASSERT_NOW(a_no_instant_answer, $rose(rsp_valid), !$past(req_valid && req_ready), "response appeared right after a request transfer")

  // A stalled response keeps its answer.
  `TAQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_answer_node), "stalled response changed")

endmodule

bind tree_ancestor_query taq_checker u_taq_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_cmd         (req.cmd),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_answer_node (rsp.answer_node)
);
